[sv/assert_macros.svh]
// assertion macros used by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define CBC_ASSERT_RST(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define CBC_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");
`else
`define CBC_ASSERT_RST(label, clk, rst_n, prop)
`define CBC_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

[sv/cbc_pkg.sv]
// shared types and constants of the cartridge bank controller
package cbc_pkg;

    localparam logic [2:0] KIND_NONE = 3'd0;
    localparam logic [2:0] KIND_MBC1 = 3'd1;
    localparam logic [2:0] KIND_MBC2 = 3'd2;
    localparam logic [2:0] KIND_MBC3 = 3'd3;
    localparam logic [2:0] KIND_MBC5 = 3'd4;

    localparam logic [3:0] LOG2_MAX   = 4'd9;
    localparam logic [3:0] LOG2_RESET = 4'd1;

    localparam logic [3:0] TOP_ROMB0 = 4'h2;
    localparam logic [3:0] TOP_ROMB1 = 4'h3;
    localparam logic [3:0] TOP_RAMB0 = 4'h4;
    localparam logic [3:0] TOP_RAMB1 = 4'h5;
    localparam logic [3:0] TOP_MODE0 = 4'h6;
    localparam logic [3:0] TOP_MODE1 = 4'h7;
    localparam logic [3:0] TOP_RAM0  = 4'hA;
    localparam logic [3:0] TOP_RAM1  = 4'hB;

    localparam logic [15:0] RAMG_LAST     = 16'h1FFF;
    localparam logic [6:0]  MBC2_RAM_PAGE = 7'b1010000;
    localparam logic [7:0]  RAMG_KEY      = 8'h0A;

    localparam int REG_ADDR_W = 3;

    typedef struct packed {
        logic [7:0] low_bits;
        logic [1:0] high_bits;
        logic [3:0] ram_sel;
        logic       ram_en;
        logic       mode;
    } t_bank_state;

    typedef struct packed {
        logic       ram_en;
        logic [3:0] ram_sel;
        logic [6:0] rom_bank_low;
        logic [8:0] rom_bank;
        logic       ram_hit;
        logic       claimed;
    } t_result;

endpackage

[sv/cbc_cfg.sv]
// apb configuration registers: controller kind and rom bank count
module cbc_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [cbc_pkg::REG_ADDR_W-1:0]     paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    output logic [2:0]                         o_kind,
    output logic [3:0]                         o_count_log2
);
    import cbc_pkg::*;

    logic [2:0] r_kind;
    logic [3:0] r_log2;
    logic       wr;

    assign wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind <= KIND_NONE;
            r_log2 <= LOG2_RESET;
        end else if (wr) begin
            if (paddr[2]) begin
                r_log2 <= pwdata[3:0];
            end else begin
                r_kind <= pwdata[2:0];
            end
        end
    end

    assign prdata       = paddr[2] ? {28'd0, r_log2} : {29'd0, r_kind};
    assign pready       = 1'b1;
    assign o_kind       = r_kind;
    assign o_count_log2 = r_log2;

endmodule

[sv/cbc_decode.sv]
// write decode, next bank state and result fields for one bus access
module cbc_decode (
    input  logic [2:0]           i_kind,
    input  logic [3:0]           i_count_log2,
    input  logic                 i_operation,
    input  logic [15:0]          i_address,
    input  logic [7:0]           i_write_data,
    input  cbc_pkg::t_bank_state i_state,
    output cbc_pkg::t_bank_state o_state,
    output cbc_pkg::t_result     o_result
);
    import cbc_pkg::*;

    logic [2:0]  kind;
    logic [3:0]  top;
    logic [3:0]  lim;
    logic [8:0]  mask;
    logic [7:0]  low_val;
    logic        claimed;
    logic        hit;
    logic        top_ramb;
    logic [9:0]  bank_raw;
    t_bank_state n_st;

    assign kind     = (i_kind > KIND_MBC5) ? KIND_NONE : i_kind;
    assign top      = i_address[15:12];
    assign lim      = (i_count_log2 > LOG2_MAX) ? LOG2_MAX : i_count_log2;
    assign mask     = 9'((10'd1 << lim) - 10'd1);
    assign top_ramb = (top == TOP_RAMB0) || (top == TOP_RAMB1);

    always_comb begin
        case (kind)
            KIND_MBC1: low_val = {3'd0, i_write_data[4:0]};
            KIND_MBC2: low_val = {4'd0, i_write_data[3:0]};
            KIND_MBC3: low_val = {1'b0, i_write_data[6:0]};
            default:   low_val = i_write_data;
        endcase
        if (low_val == 8'd0 && kind != KIND_MBC5) begin
            low_val = 8'd1;
        end
    end

    always_comb begin
        n_st    = i_state;
        claimed = 1'b0;
        if (!i_operation && kind != KIND_NONE) begin
            if ((kind == KIND_MBC5 && top == TOP_ROMB0) ||
                (kind != KIND_MBC5 && (top == TOP_ROMB0 || top == TOP_ROMB1))) begin
                n_st.low_bits = low_val;
                claimed       = 1'b1;
            end else if (kind == KIND_MBC1 && top_ramb) begin
                n_st.high_bits = i_write_data[1:0];
                n_st.ram_sel   = {2'd0, i_write_data[1:0]};
                claimed        = 1'b1;
            end else if (kind == KIND_MBC5 && top == TOP_ROMB1) begin
                n_st.high_bits = {1'b0, i_write_data[0]};
                claimed        = 1'b1;
            end else if (i_address <= RAMG_LAST) begin
                n_st.ram_en = ((i_write_data & RAMG_KEY) == RAMG_KEY);
                claimed     = 1'b1;
            end else if (top_ramb && kind == KIND_MBC3 && i_state.ram_sel[3:2] == 2'd0) begin
                n_st.ram_sel = {2'd0, i_write_data[1:0]};
                claimed      = 1'b1;
            end else if (top_ramb && kind == KIND_MBC5) begin
                n_st.ram_sel = i_write_data[3:0];
                claimed      = 1'b1;
            end else if (kind == KIND_MBC1 && (top == TOP_MODE0 || top == TOP_MODE1)) begin
                n_st.mode = i_write_data[0];
                claimed   = 1'b1;
            end
        end
    end

    always_comb begin
        case (kind)
            KIND_NONE: hit = 1'b0;
            KIND_MBC2: hit = (i_address[15:9] == MBC2_RAM_PAGE);
            default:   hit = (top == TOP_RAM0) || (top == TOP_RAM1);
        endcase
    end

    assign bank_raw = (kind == KIND_MBC5) ? ({n_st.high_bits, 8'd0} | {2'd0, n_st.low_bits})
                                          : ({3'd0, n_st.high_bits, 5'd0} | {2'd0, n_st.low_bits});

    assign o_state               = n_st;
    assign o_result.claimed      = claimed;
    assign o_result.ram_hit      = hit;
    assign o_result.rom_bank     = bank_raw[8:0] & mask;
    assign o_result.rom_bank_low = (kind == KIND_MBC1 && n_st.mode && lim >= 4'd6)
                                   ? ({n_st.high_bits, 5'd0} & mask[6:0]) : 7'd0;
    assign o_result.ram_sel      = n_st.ram_sel;
    assign o_result.ram_en       = n_st.ram_en;

endmodule

[sv/cartridge_bank_controller.sv]
// top level of the cartridge bank controller
//
// one bus access enters per beat on the slave stream: tuser carries the
// operation (0 write, 1 read), tdata carries address and write byte. each
// access leaves one result beat on the master stream in the cycle after it is
// taken, holding the claim flag, the ram window flag and the bank selection
// as it stands after the access.
// throughput is one access per cycle: the bank registers update at the edge
// that takes the beat, so the next access sees them in the following cycle.
// a single output register holds the result; a new beat is taken whenever
// that register is empty or is being drained in the same cycle, so a stall
// on the master side stops input only while the held beat waits.
// the apb port sets controller kind (offset 0x0) and the log2 rom bank
// count (offset 0x4); write it only while no access is in flight.
// synchronous reset empties the output register, sets the low rom bank
// bits to 1, clears the other bank state and selects no controller with a
// two-bank rom.
module cartridge_bank_controller (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // address[15:0], write_data[23:16]
    input  logic        i_s_tuser,   // operation
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // write_claimed, ram_window_hit, rom_bank[10:2],
                                     // rom_bank_low_area[17:11], ram_bank_out[21:18],
                                     // ram_enabled[22], zero pad
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [cbc_pkg::REG_ADDR_W-1:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import cbc_pkg::*;
    `include "assert_macros.svh"

    logic [2:0]  kind;
    logic [3:0]  count_log2;
    logic        acc;
    t_bank_state r_state;
    t_bank_state n_state;
    t_result     res;
    logic        r_valid;
    logic [23:0] r_tdata;

    cbc_cfg u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_kind       (kind),
        .o_count_log2 (count_log2)
    );

    cbc_decode u_decode (
        .i_kind       (kind),
        .i_count_log2 (count_log2),
        .i_operation  (i_s_tuser),
        .i_address    (i_s_tdata[15:0]),
        .i_write_data (i_s_tdata[23:16]),
        .i_state      (r_state),
        .o_state      (n_state),
        .o_result     (res)
    );

    assign o_s_tready = !r_valid || i_m_tready;
    assign acc        = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.low_bits  <= 8'd1;
            r_state.high_bits <= 2'd0;
            r_state.ram_sel   <= 4'd0;
            r_state.ram_en    <= 1'b0;
            r_state.mode      <= 1'b0;
            r_valid           <= 1'b0;
        end else begin
            if (acc) begin
                r_state <= n_state;
                r_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_tdata <= {1'b0, res.ram_en, res.ram_sel, res.rom_bank_low,
                        res.rom_bank, res.ram_hit, res.claimed};
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = r_tdata;

    `CBC_ASSERT_RST(a_read_keeps_state, i_clk, i_rst_n, (acc && i_s_tuser) |=> $stable(r_state))
    `CBC_ASSERT_RST(a_none_keeps_state, i_clk, i_rst_n, (acc && kind == KIND_NONE) |=> $stable(r_state))
    `CBC_ASSERT_RST(a_accept_fills, i_clk, i_rst_n, acc |=> r_valid)
    `CBC_ASSERT_RST(a_read_not_claimed, i_clk, i_rst_n, (acc && i_s_tuser) |=> !r_tdata[0])
    `CBC_ASSERT_ALWAYS(a_reset_state, i_clk, !i_rst_n |=> (r_state.low_bits == 8'd1 && !r_valid))

endmodule
